// ===== sv/rrt_pkg.sv =====
// Types and constants shared by the retransmit table modules.
package rrt_pkg;

  // Input operation codes
  localparam logic [2:0] OP_REMEMBER    = 3'd0;
  localparam logic [2:0] OP_ACK         = 3'd1;
  localparam logic [2:0] OP_TICK        = 3'd2;
  localparam logic [2:0] OP_FORGET_PEER = 3'd3;
  localparam logic [2:0] OP_FORGET_ALL  = 3'd4;
  localparam logic [2:0] OP_DATA        = 3'd5;

  // Result kinds
  localparam logic [1:0] KIND_RESEND = 2'd0;
  localparam logic [1:0] KIND_ACK    = 2'd1;
  localparam logic [1:0] KIND_FULL   = 2'd2;

  // Configuration register indexes
  localparam logic [2:0] CFG_RESEND_RATE  = 3'd0;
  localparam logic [2:0] CFG_LONG_BASE    = 3'd1;
  localparam logic [2:0] CFG_CAP          = 3'd2;
  localparam logic [2:0] CFG_MAX_ATTEMPTS = 3'd3;
  localparam logic [2:0] CFG_SERVER_PRES  = 3'd4;
  localparam logic [2:0] CFG_SERVER_PEER  = 3'd5;

  typedef struct packed {
    logic        valid;
    logic [15:0] seq;
    logic [7:0]  peer;
    logic [7:0]  handle;
    logic [1:0]  cls;        // bit 0 long class, bit 1 join request
    logic [31:0] last_send;
    logic [3:0]  attempts;
  } entry_t;

  typedef enum logic [2:0] {
    CELL_HOLD,
    CELL_ROTATE,
    CELL_SQUEEZE,
    CELL_APPEND,
    CELL_CLEAR
  } cell_cmd_t;

  typedef struct packed {
    cell_cmd_t cmd;
    entry_t    wr;
  } cell_ctl_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  peer;
    logic [15:0] seq;
    logic [7:0]  handle;
    logic        gave_up;
    logic        last;
  } result_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_CALC,
    S_EVAL,
    S_SQUEEZE
  } state_t;

endpackage

// ===== sv/rrt_if.sv =====
// Valid/ready channel interfaces for table requests and results.
interface rrt_item_if;
  logic       valid;
  logic       ready;
  logic [2:0] op;
  logic [15:0] seq_id;
  logic [7:0] peer;
  logic [7:0] handle;
  logic       reliable;
  logic       already_sent;
  logic       write_error;
  logic       long_class;
  logic       join_request;

  modport source (output valid, op, seq_id, peer, handle, reliable, already_sent,
                  write_error, long_class, join_request, input ready);
  modport sink (input valid, op, seq_id, peer, handle, reliable, already_sent,
                write_error, long_class, join_request, output ready);
endinterface

interface rrt_result_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [7:0]  out_peer;
  logic [15:0] out_seq;
  logic [7:0]  out_handle;
  logic        gave_up;
  logic        last;

  modport source (output valid, kind, out_peer, out_seq, out_handle, gave_up, last,
                  input ready);
  modport sink (input valid, kind, out_peer, out_seq, out_handle, gave_up, last,
                output ready);
endinterface

// ===== sv/rrt_cell.sv =====
// One table slot: holds an entry and moves it toward its left neighbor.
module rrt_cell (
  input  logic              clk,
  input  logic              rst,
  input  rrt_pkg::cell_ctl_t ctl,
  input  rrt_pkg::entry_t   right,
  input  logic              left_valid,
  input  logic              hole_in,
  output logic              hole_out,
  output rrt_pkg::entry_t   q
);
  import rrt_pkg::*;

  entry_t q_next;

  always_comb begin
    q_next = q;
    case (ctl.cmd)
      CELL_ROTATE: q_next = right;
      CELL_SQUEEZE: begin
        // close every gap at or left of this slot by one place
        if (hole_in || !q.valid) q_next = right;
      end
      CELL_APPEND: begin
        if (!q.valid && left_valid) q_next = ctl.wr;
      end
      CELL_CLEAR: q_next.valid = 1'b0;
      default: q_next = q;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      q.valid <= 1'b0;
    end else begin
      q <= q_next;
    end
  end

  assign hole_out = hole_in || !q.valid;

endmodule

// ===== sv/reliable_retransmit_table_unit.sv =====
// Top level of the reliable packet retransmit table.
// Retransmit table for unacknowledged reliable packets, kept in insertion order in a
// row of ENTRIES slots. Remember, forget-all and data-received items are handled in the
// idle state. Ack, tick and forget-peer (nonzero peer only) rotate the whole row once
// through slot 0, each slot in a timeout step, then a decision step; a compaction pass
// then closes the gaps left by removed entries. Resends leave in order; a stalled result
// channel holds the rotation. Configuration is written through cfg_we/cfg_index/cfg_data;
// the user writes it only while the table is idle, the block itself does not enforce this.
module reliable_retransmit_table_unit #(
  parameter int ENTRIES = 16
) (
  input  logic        clk,
  input  logic        rst,
  rrt_item_if.sink    items,
  rrt_result_if.source results,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [11:0] cfg_data
);
  import rrt_pkg::*;

  localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

  // configuration
  logic [7:0]  resend_rate;
  logic [7:0]  long_base;
  logic [11:0] cap;
  logic [3:0]  max_attempts;
  logic        server_present;
  logic [7:0]  server_peer;

  state_t state, state_next;
  logic [31:0] now;
  logic [IDX_W-1:0] cnt;
  logic [11:0] tmo;
  logic        found;
  logic [2:0]  op_r;
  logic [15:0] seq_r;
  logic [7:0]  peer_r;
  result_t     pend;
  logic        pend_valid;
  result_t     out_q;
  logic        out_valid;

  cell_ctl_t ctl;
  entry_t    tail;
  entry_t    cq [ENTRIES];
  logic      hole [ENTRIES];
  logic [ENTRIES-1:0] gap_bits;

  genvar g;
  generate
    for (g = 0; g < ENTRIES; g++) begin : g_cell
      entry_t r_in;
      logic   lv;
      logic   hin;
      if (g == ENTRIES - 1) begin : g_end
        assign r_in = tail;
      end else begin : g_mid
        assign r_in = cq[g+1];
      end
      if (g == 0) begin : g_head
        assign lv  = 1'b1;
        assign hin = 1'b0;
      end else begin : g_body
        assign lv  = cq[g-1].valid;
        assign hin = hole[g-1];
      end
      assign gap_bits[g] = hin && cq[g].valid;
      rrt_cell u_cell (
        .clk        (clk),
        .rst        (rst),
        .ctl        (ctl),
        .right      (r_in),
        .left_valid (lv),
        .hole_in    (hin),
        .hole_out   (hole[g]),
        .q          (cq[g])
      );
    end
  endgenerate

  logic acc, out_free, compact, full;
  logic [31:0] diff;
  logic due, gave, stall, eval_go, drop;
  logic [3:0]  att1;
  logic [11:0] prod;
  logic [12:0] lng, t13;
  logic [11:0] tmo_calc;
  entry_t      head, proc;
  result_t     r_new;
  logic        out_load;
  result_t     out_d;
  logic        push_pend;

  assign head     = cq[0];
  assign out_free = !out_valid || results.ready;
  assign items.ready = (state == S_IDLE) && out_free;
  assign acc      = items.valid && items.ready;
  assign compact  = !(|gap_bits);
  assign full     = cq[ENTRIES-1].valid;

  assign prod = {8'b0, head.attempts} * {4'b0, resend_rate};
  assign lng  = {5'b0, long_base} + {prod, 1'b0};
  assign t13  = head.cls[0] ? lng : {1'b0, prod};
  assign tmo_calc = (t13 > {1'b0, cap}) ? cap : t13[11:0];

  assign diff  = now - head.last_send;
  assign due   = (op_r == OP_TICK) && head.valid && (diff > {20'b0, tmo});
  assign att1  = head.attempts + 4'd1;
  assign gave  = att1 >= max_attempts;
  assign stall = due && pend_valid && !out_free;
  assign eval_go = !stall;
  assign drop  = ((op_r == OP_ACK) && head.valid && (head.seq == seq_r) && !found) ||
                 ((op_r == OP_FORGET_PEER) && head.valid && (head.peer == peer_r));

  always_comb begin
    proc = head;
    if (due) begin
      if (head.cls[1] && server_present) proc.peer = server_peer;
      proc.last_send = now;
      proc.attempts  = att1;
      proc.valid     = !gave;
    end
    if (drop) proc.valid = 1'b0;
  end

  always_comb begin
    r_new.kind    = KIND_RESEND;
    r_new.peer    = proc.peer;
    r_new.seq     = head.seq;
    r_new.handle  = head.handle;
    r_new.gave_up = gave;
    r_new.last    = 1'b0;
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (acc) begin
          unique case (items.op) inside
            OP_ACK, OP_TICK: state_next = S_CALC;
            OP_FORGET_PEER: if (items.peer != 8'd0) state_next = S_CALC;
            default: state_next = S_IDLE;
          endcase
        end
      end
      S_CALC: state_next = S_EVAL;
      S_EVAL: begin
        if (eval_go) state_next = (cnt == LAST_IDX) ? S_SQUEEZE : S_CALC;
      end
      S_SQUEEZE: begin
        if (compact && (!pend_valid || out_free)) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // outputs to cells and result register
  always_comb begin
    ctl.cmd = CELL_HOLD;
    ctl.wr.valid     = 1'b1;
    ctl.wr.seq       = items.seq_id;
    ctl.wr.peer      = items.peer;
    ctl.wr.handle    = items.handle;
    ctl.wr.cls       = {items.join_request, items.long_class};
    ctl.wr.last_send = now;
    ctl.wr.attempts  = 4'd1;
    tail       = proc;
    tail.valid = 1'b0;
    out_load   = 1'b0;
    out_d      = pend;
    push_pend  = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (acc) begin
          out_d.peer    = items.peer;
          out_d.seq     = items.seq_id;
          out_d.handle  = items.handle;
          out_d.gave_up = 1'b0;
          out_d.last    = 1'b1;
          out_d.kind    = KIND_FULL;
          if (items.op == OP_REMEMBER && items.reliable && !items.already_sent &&
              !items.write_error) begin
            if (full) out_load = 1'b1;
            else ctl.cmd = CELL_APPEND;
          end else if (items.op == OP_FORGET_ALL) begin
            ctl.cmd = CELL_CLEAR;
          end else if (items.op == OP_DATA && items.seq_id != 16'd0) begin
            out_d.kind   = KIND_ACK;
            out_d.peer   = 8'd0;
            out_d.handle = 8'd0;
            out_load     = 1'b1;
          end
        end
      end
      S_EVAL: begin
        if (eval_go) begin
          ctl.cmd = CELL_ROTATE;
          tail    = proc;
          if (due && pend_valid) begin
            out_load  = 1'b1;
            push_pend = 1'b1;
          end
        end
      end
      S_SQUEEZE: begin
        ctl.cmd = CELL_SQUEEZE;
        if (pend_valid && out_free) begin
          out_d.last = 1'b1;
          out_load   = 1'b1;
          push_pend  = 1'b1;
        end
      end
      default: ctl.cmd = CELL_HOLD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      now            <= 32'd0;
      out_valid      <= 1'b0;
      pend_valid     <= 1'b0;
      resend_rate    <= 8'd7;
      long_base      <= 8'd20;
      cap            <= 12'd500;
      max_attempts   <= 4'd15;
      server_present <= 1'b0;
      server_peer    <= 8'd0;
    end else begin
      state <= state_next;
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_RESEND_RATE:  resend_rate    <= cfg_data[7:0];
          CFG_LONG_BASE:    long_base      <= cfg_data[7:0];
          CFG_CAP:          cap            <= cfg_data;
          CFG_MAX_ATTEMPTS: max_attempts   <= cfg_data[3:0];
          CFG_SERVER_PRES:  server_present <= cfg_data[0];
          CFG_SERVER_PEER:  server_peer    <= cfg_data[7:0];
          default: ;
        endcase
      end
      if (acc && items.op == OP_TICK) now <= now + 32'd1;
      if (out_load) out_valid <= 1'b1;
      else if (results.ready) out_valid <= 1'b0;
      if (state == S_EVAL && eval_go && due) pend_valid <= 1'b1;
      else if (push_pend) pend_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      op_r   <= items.op;
      seq_r  <= items.seq_id;
      peer_r <= items.peer;
      cnt    <= '0;
      found  <= 1'b0;
    end
    if (state == S_CALC) tmo <= tmo_calc;
    if (state == S_EVAL && eval_go) begin
      cnt <= cnt + 1'b1;
      if (drop) found <= 1'b1;
      if (due) pend <= r_new;
    end
    if (out_load) out_q <= out_d;
  end

  assign results.valid      = out_valid;
  assign results.kind       = out_q.kind;
  assign results.out_peer   = out_q.peer;
  assign results.out_seq    = out_q.seq;
  assign results.out_handle = out_q.handle;
  assign results.gave_up    = out_q.gave_up;
  assign results.last       = out_q.last;

`ifndef SYNTHESIS
  a_idle_compact: assert property (@(posedge clk) disable iff (rst)
    state == S_IDLE |-> compact) else $error("table not compact when idle");
  a_idle_no_pend: assert property (@(posedge clk) disable iff (rst)
    state == S_IDLE |-> !pend_valid) else $error("pending resend left behind");
  a_clear_all: assert property (@(posedge clk) disable iff (rst)
    (acc && items.op == OP_FORGET_ALL) |=> !cq[0].valid)
    else $error("forget-all left an entry");
  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !results.ready) |-> !out_load) else $error("result overwritten");
`endif

endmodule
